/* rtl/itrd_pkg.sv */
// Shared types, sizes and helpers for the integer to radix digit converter.
package itrd_pkg;

  // Width of the integer to convert.
  localparam int unsigned VALUE_WIDTH = 31;
  // Width of the radix field.
  localparam int unsigned RADIX_WIDTH = 5;
  // Entries in the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;
  // Smallest and largest radix that produce digits.
  localparam logic [RADIX_WIDTH-1:0] RadixMin = RADIX_WIDTH'(2);
  localparam logic [RADIX_WIDTH-1:0] RadixMax = RADIX_WIDTH'(16);
  // Digit values below this are decimal characters.
  localparam logic [3:0] DecimalDigits = 4'd10;
  localparam logic [6:0] AsciiZero = 7'h30;
  localparam logic [6:0] AsciiUpperA = 7'h41;

  // One input item.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_WIDTH-1:0] radix;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [3:0] digit_value;
    logic [6:0] digit_char;
    logic       last_digit;
    logic       bad_radix;
  } out_t;

  // A classified item waiting for the back part.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_WIDTH-1:0] radix;
    logic                   bad;
  } work_t;

  // ASCII character of a digit value: '0'-'9', then 'A'-'F'.
  function automatic logic [6:0] ascii_of(input logic [3:0] d);
    logic [6:0] ch;
    if (d < DecimalDigits) begin
      ch = AsciiZero + {3'b000, d};
    end else begin
      ch = AsciiUpperA + {3'b000, d - DecimalDigits};
    end
    return ch;
  endfunction

endpackage

/* rtl/itrd_front.sv */
// Front part: accepts input items, checks the radix and queues the work.
module itrd_front
  import itrd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  output logic  full,
  input  in_t   in_data_i,
  output logic  item_valid_o,
  output work_t item_o,
  input  logic  item_take_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  work_t            queue_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push_xfer;
  logic             take_xfer;
  work_t            classified;

  // Classify the incoming item by its radix.
  always_comb begin
    classified.value = in_data_i.value;
    classified.radix = in_data_i.radix;
    classified.bad   = (in_data_i.radix < RadixMin) || (in_data_i.radix > RadixMax);
  end

  assign full         = (count_q == CntW'(QUEUE_DEPTH));
  assign push_xfer    = push && !full;
  assign item_valid_o = (count_q != '0);
  assign take_xfer    = item_take_i && item_valid_o;
  assign item_o       = queue_q[rd_ptr_q];

  // Pointer and fill count updates with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_xfer) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (take_xfer) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_xfer && !take_xfer) begin
      count_d = count_q + 1'b1;
    end else if (!push_xfer && take_xfer) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_xfer) begin
      queue_q[wr_ptr_q] <= classified;
    end
  end

endmodule

/* rtl/itrd_back.sv */
// Back part: finds the leading place value, then produces digits one by one.
module itrd_back
  import itrd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  input  work_t item_i,
  output logic  item_take_o,
  output logic  out_valid_o,
  output out_t  out_data_o,
  input  logic  pop
);

  localparam int unsigned IdxW  = $clog2(VALUE_WIDTH);
  localparam int unsigned ProdW = VALUE_WIDTH + RADIX_WIDTH;
  localparam int unsigned TrialW = VALUE_WIDTH + 3;

  typedef enum logic [1:0] {
    StIdle,
    StAscend,
    StDigit,
    StEmit
  } state_e;

  state_e                 state_q;
  logic [VALUE_WIDTH-1:0] rem_q;
  logic [VALUE_WIDTH-1:0] place_q;
  logic [RADIX_WIDTH-1:0] radix_q;
  logic [IdxW-1:0]        idx_q;
  logic [1:0]             bit_q;
  logic [3:0]             digit_q;
  logic                   bad_q;
  logic                   out_valid_q;
  out_t                   out_q;
  logic [VALUE_WIDTH-1:0] pow_q [VALUE_WIDTH];

  logic [ProdW-1:0]       prod;
  logic                   prod_fits;
  logic [TrialW-1:0]      trial;
  logic                   trial_fits;
  logic                   pop_xfer;
  logic                   slot_free;
  logic                   emit_xfer;
  logic                   is_last;
  out_t                   result;

  // Next place value candidate and the digit trial subtraction.
  assign prod       = ProdW'(place_q) * ProdW'(radix_q);
  assign prod_fits  = (prod <= ProdW'(rem_q));
  assign trial      = TrialW'(place_q) << bit_q;
  assign trial_fits = (trial <= TrialW'(rem_q));

  assign pop_xfer    = pop && out_valid_q;
  assign slot_free   = !out_valid_q || pop_xfer;
  assign emit_xfer   = (state_q == StEmit) && slot_free;
  assign item_take_o = (state_q == StIdle) && item_valid_i;
  assign is_last     = bad_q || (idx_q == '0);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Result of the digit now finished.
  always_comb begin
    result.digit_value = bad_q ? 4'd0 : digit_q;
    result.digit_char  = bad_q ? 7'd0 : ascii_of(digit_q);
    result.last_digit  = is_last;
    result.bad_radix   = bad_q;
  end

  // Conversion sequencer and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rem_q       <= '0;
      place_q     <= '0;
      radix_q     <= '0;
      idx_q       <= '0;
      bit_q       <= '0;
      digit_q     <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // The output register fills on an emitted digit and drains on a transfer.
      if (emit_xfer) begin
        out_valid_q <= 1'b1;
      end else if (pop_xfer) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (item_valid_i) begin
            rem_q   <= item_i.value;
            radix_q <= item_i.radix;
            bad_q   <= item_i.bad;
            place_q <= VALUE_WIDTH'(1);
            idx_q   <= '0;
            digit_q <= '0;
            state_q <= item_i.bad ? StEmit : StAscend;
          end
        end
        StAscend: begin
          // Grow the place value while another multiple still fits.
          if (prod_fits) begin
            place_q <= prod[VALUE_WIDTH-1:0];
            idx_q   <= idx_q + 1'b1;
          end else begin
            bit_q   <= 2'd3;
            digit_q <= '0;
            state_q <= StDigit;
          end
        end
        StDigit: begin
          // One quotient bit of the digit per cycle.
          if (trial_fits) begin
            rem_q   <= rem_q - trial[VALUE_WIDTH-1:0];
            digit_q <= digit_q | (4'd1 << bit_q);
          end
          if (bit_q == 2'd0) begin
            state_q <= StEmit;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        StEmit: begin
          if (slot_free) begin
            out_q <= result;
            if (is_last) begin
              state_q <= StIdle;
            end else begin
              idx_q   <= idx_q - 1'b1;
              place_q <= pow_q[idx_q - 1'b1];
              bit_q   <= 2'd3;
              digit_q <= '0;
              state_q <= StDigit;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Place values kept on the way up, read back on the way down.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) begin
      pow_q[0] <= VALUE_WIDTH'(1);
    end else if (state_q == StAscend && prod_fits) begin
      pow_q[idx_q + 1'b1] <= prod[VALUE_WIDTH-1:0];
    end
  end

  // A bad radix result always closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.bad_radix |-> out_q.last_digit)
    else $error("bad radix result without last flag");

  // Digits are always below the radix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) && !bad_q |-> (RADIX_WIDTH'(digit_q) < radix_q))
    else $error("digit not below radix");

  // The place value never drops to zero while digits are produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDigit) || (state_q == StAscend) |-> (place_q != '0))
    else $error("zero place value");

  // The remainder holds while the place value grows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAscend) |=> $stable(rem_q))
    else $error("remainder changed during ascent");

  // A new result is loaded only into a free output slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) && out_valid_q && !pop |=> $stable(out_q))
    else $error("output overwritten");

endmodule

/* rtl/integer_to_radix_digits.sv */
// Top level of the integer to radix digit converter.
//
//   Channel   Handshake               Payload    Transfer when
//   input     push / full             in_data_i  push && !full
//   result    empty / pop             out_data_o pop && !empty
//
// The back part loads a value, searches the leading place value with one
// multiply per cycle, then finds each digit by a trial of four quotient
// bits and emits it. A bad radix goes straight from the load to the emit.
// The input queue holds two items, so input keeps flowing while a
// conversion runs; a result waiting in the output register stalls only
// the back part. Reset empties both queues at once.
module integer_to_radix_digits
  import itrd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  in_data_i,
  output logic empty,
  input  logic pop,
  output out_t out_data_o
);

  logic  item_valid;
  logic  item_take;
  work_t item;
  logic  out_valid;

  itrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_take_i (item_take)
  );

  itrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_take_o (item_take),
    .out_valid_o (out_valid),
    .out_data_o  (out_data_o),
    .pop         (pop)
  );

  assign empty = !out_valid;

endmodule

/* verif/integer_to_radix_digits_test.sv */
// Self-checking testbench for the integer to radix digit converter.
module integer_to_radix_digits_test
  import itrd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The longest quiet stretch in a correct run is the long receiver hold-off
  // (HOLD_CYCLES) plus a radix-2 conversion. The limit is several times
  // that sum.
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  // Time left for stray results after the last expected one.
  localparam int unsigned TAIL_CYCLES = 250;
  localparam int unsigned RANDOM_ITEMS = 440;
  localparam int unsigned HOLD_AFTER = 120;
  localparam int unsigned MAX_ERROR_LINES = 100;
  localparam longint unsigned ValueMask = (64'd1 << VALUE_WIDTH) - 64'd1;

  // Results whose expectation can be typed in directly.
  localparam out_t ResultZero = '{4'd0, AsciiZero, 1'b1, 1'b0};
  localparam out_t ResultBad = '{4'd0, 7'd0, 1'b1, 1'b1};

  // One line of the stimulus table.
  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_WIDTH-1:0] radix;
    bit                     typed;
    out_t                   want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  in_t  in_data = '0;
  logic full;
  logic empty;
  out_t out_data;

  stim_row_t plan[$];
  out_t      digits_due[$];
  int        errors = 0;
  bit        feed_done = 1'b0;

  integer_to_radix_digits u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .push      (push),
    .full      (full),
    .in_data_i (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data)
  );

  // Free-running clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Reset is held low from the start and released on a falling edge.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Logs one mismatch and counts it.
  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_ERROR_LINES) begin
      $display("ERROR at %0t ns: %s", $realtime, msg);
    end
  endtask

  // Expected digit string of one item, most significant digit first.
  function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] value,
                                         input logic [RADIX_WIDTH-1:0] radix);
    longint unsigned base;
    longint unsigned rest;
    longint unsigned place;
    longint unsigned d;
    out_t res;
    if (radix < RadixMin || radix > RadixMax) begin
      digits_due.push_back(ResultBad);
      return;
    end
    base = radix;
    rest = value;
    place = 1;
    // Leading place value: largest power of the radix not above the value.
    while (place <= rest / base) begin
      place = place * base;
    end
    while (place != 0) begin
      d = rest / place;
      rest = rest - d * place;
      place = place / base;
      res.digit_value = 4'(d);
      if (d < DecimalDigits) begin
        res.digit_char = AsciiZero + 7'(d);
      end else begin
        res.digit_char = AsciiUpperA + 7'(d - DecimalDigits);
      end
      res.last_digit = (place == 0);
      res.bad_radix = 1'b0;
      digits_due.push_back(res);
    end
  endfunction

  // Compares one transferred result with the oldest expectation.
  task automatic check_digit(input out_t got);
    out_t want;
    if (digits_due.size() == 0) begin
      flag_error($sformatf("result %h with nothing expected", got));
      return;
    end
    want = digits_due.pop_front();
    if (got.digit_value !== want.digit_value) begin
      flag_error($sformatf("digit_value %h, expected %h", got.digit_value, want.digit_value));
    end
    if (got.digit_char !== want.digit_char) begin
      flag_error($sformatf("digit_char %h, expected %h", got.digit_char, want.digit_char));
    end
    if (got.last_digit !== want.last_digit) begin
      flag_error($sformatf("last_digit %b, expected %b", got.last_digit, want.last_digit));
    end
    if (got.bad_radix !== want.bad_radix) begin
      flag_error($sformatf("bad_radix %b, expected %b", got.bad_radix, want.bad_radix));
    end
  endtask

  // Builds the stimulus table, then offers its rows one transfer at a time.
  initial begin : feed_items
    int gap;
    bit burst;
    longint unsigned pw;
    logic [VALUE_WIDTH-1:0] v;
    logic [RADIX_WIDTH-1:0] r;
    // Directed rows: zero, bad radixes, extremes and place value boundaries.
    plan.push_back('{31'd0, 5'd2, 1'b1, ResultZero});
    plan.push_back('{31'd0, 5'd16, 1'b1, ResultZero});
    plan.push_back('{31'd0, 5'd10, 1'b1, ResultZero});
    plan.push_back('{'1, 5'd0, 1'b1, ResultBad});
    plan.push_back('{31'd5, 5'd1, 1'b1, ResultBad});
    plan.push_back('{'1, 5'd17, 1'b1, ResultBad});
    plan.push_back('{31'd0, 5'd31, 1'b1, ResultBad});
    plan.push_back('{31'd12345, 5'd24, 1'b1, ResultBad});
    plan.push_back('{31'd1, 5'd2, 1'b1, '{4'd1, 7'h31, 1'b1, 1'b0}});
    plan.push_back('{31'd1, 5'd16, 1'b1, '{4'd1, 7'h31, 1'b1, 1'b0}});
    plan.push_back('{31'd15, 5'd16, 1'b1, '{4'd15, 7'h46, 1'b1, 1'b0}});
    plan.push_back('{31'd9, 5'd10, 1'b1, '{4'd9, 7'h39, 1'b1, 1'b0}});
    plan.push_back('{'1, 5'd2, 1'b0, '0});
    plan.push_back('{'1, 5'd16, 1'b0, '0});
    plan.push_back('{'1, 5'd10, 1'b0, '0});
    plan.push_back('{'1, 5'd3, 1'b0, '0});
    plan.push_back('{31'd16, 5'd16, 1'b0, '0});
    plan.push_back('{31'h4000_0000, 5'd2, 1'b0, '0});
    plan.push_back('{31'h3FFF_FFFF, 5'd2, 1'b0, '0});
    plan.push_back('{31'd1_000_000_000, 5'd10, 1'b0, '0});
    plan.push_back('{31'd255, 5'd15, 1'b0, '0});
    plan.push_back('{31'h5555_5555, 5'd7, 1'b0, '0});
    plan.push_back('{31'h2AAA_AAAA, 5'd12, 1'b0, '0});
    plan.push_back('{31'd6, 5'd6, 1'b0, '0});
    // Random rows: mostly valid radixes with values of every length, some
    // near a power of the radix, and a few bad radixes.
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        r = $urandom_range(0, 1) ? 5'($urandom_range(0, 1)) : 5'($urandom_range(17, 31));
        v = 31'($urandom);
      end else begin
        r = 5'($urandom_range(2, 16));
        if ($urandom_range(0, 5) == 0) begin
          pw = 1;
          repeat ($urandom_range(0, 30)) begin
            if (pw * r <= ValueMask) pw = pw * r;
          end
          v = $urandom_range(0, 1) ? 31'(pw) : 31'(pw - 1);
        end else begin
          v = 31'(longint'($urandom) & ((64'd1 << $urandom_range(1, VALUE_WIDTH)) - 64'd1));
        end
      end
      plan.push_back('{v, r, 1'b0, '0});
    end

    burst = 1'b0;
    wait (rst_n);
    foreach (plan[i]) begin
      @(negedge clk);
      if (i % 16 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      push <= 1'b1;
      in_data <= '{value: plan[i].value, radix: plan[i].radix};
      do @(posedge clk); while (full);
      if (plan[i].typed) begin
        digits_due.push_back(plan[i].want);
      end else begin
        predict_digits(plan[i].value, plan[i].radix);
      end
    end
    @(negedge clk);
    push <= 1'b0;
    feed_done = 1'b1;
  end

  // Takes results with random stalls and one long hold-off that fills the block.
  initial begin : drain_results
    int gap;
    int taken;
    bit burst;
    bit held;
    taken = 0;
    burst = 1'b0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (taken % 16 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 3);
      if (!held && taken == HOLD_AFTER) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_digit(out_data);
      taken++;
    end
  end

  // Ends the run when no transfer happens for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
    $display("FAIL integer_to_radix_digits");
    $finish;
  end

  // Waits for every expected result, lets stray ones show up, then reports.
  initial begin : finish_run
    wait (feed_done);
    while (digits_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS integer_to_radix_digits");
    end else begin
      $display("FAIL integer_to_radix_digits");
    end
    $finish;
  end

endmodule
